@@ hdl/ldsk_pkg.sv @@
// ----------------------------------------------------------------------------
// ldsk_pkg
// shared constants, types and codes of the look disk scheduler
// ----------------------------------------------------------------------------
package ldsk_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int CYL_BITS    = 12;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_BITS    = 16;
   localparam int CSR_ADDR_W  = 1;
   localparam int REQ_DATA_W  = ((CYL_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_W = CYL_BITS + CYL_BITS + SUM_BITS + 1;
   localparam int RSP_DATA_W  = ((RSP_FIELD_W + 7) / 8) * 8;

   localparam logic [CYL_BITS-1:0] HEAD_RESET = CYL_BITS'(143);
   localparam logic [CYL_BITS-1:0] PREV_RESET = CYL_BITS'(145);
   localparam logic [SUM_BITS-1:0] SUM_MAX    = '1;

   localparam logic [CSR_ADDR_W-1:0] CSR_HEAD_POSITION     = CSR_ADDR_W'(0);
   localparam logic [CSR_ADDR_W-1:0] CSR_PREVIOUS_POSITION = CSR_ADDR_W'(1);

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SETUP,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic                valid;
      logic                gt;
      logic [CYL_BITS-1:0] data;
   } link_type;

endpackage

@@ hdl/look_disk_scheduler.sv @@
// ----------------------------------------------------------------------------
// look_disk_scheduler
// LOOK disk scheduler built on a sorted chain of request cells
//
// req_ words carry one cylinder request each; tlast closes the batch.
// While loading, one request is taken per cycle and inserted in sorted
// position along the cell chain in that same cycle. Requests beyond the
// chain depth are dropped and flag the whole batch as overflowed.
// After the closing word the block finds the split point against the
// head position in its setup state, then emits one rsp_ word per stored
// request in LOOK order, at most one per cycle while rsp_tready allows.
// req_tready is low from the closing word until the final rsp_ word has
// left the emit stage. rsp_ words sit in an output register; when the
// receiver holds rsp_tready low the emission simply pauses there.
// The head and previous positions are written through csr_; this must
// only be done between batches, which the block itself does not enforce.
// Reset empties the chain and sets the head to 143 and the previous
// position to 145.
// ----------------------------------------------------------------------------
module look_disk_scheduler (
   input  logic                                clock,
   input  logic                                reset,
   // csr
   input  logic                                csr_we,
   input  logic [ldsk_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [ldsk_pkg::CYL_BITS-1:0]       csr_wdata,
   // request stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [ldsk_pkg::REQ_DATA_W-1:0]     req_tdata,  // cylinder
   input  logic                                req_tlast,
   // response stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // served_cylinder, seek_distance, total_distance, overflow
   output logic [ldsk_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast
);
   import ldsk_pkg::*;

   state_type state_ff, state_in;

   logic [CYL_BITS-1:0] head_ff, prev_ff;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                drop_ff, drop_in;
   logic [CNT_W-1:0]    split_ff, split_in;
   logic [IDX_W-1:0]    ptr_ff, ptr_in;
   logic                up_ff, up_in;
   logic                pend_ff, pend_in;
   logic [CYL_BITS-1:0] track_ff, track_in;
   logic [SUM_BITS-1:0] sum_ff, sum_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_last_ff, rsp_last_in;
   logic [CYL_BITS-1:0] rsp_cyl_ff, rsp_cyl_in;
   logic [CYL_BITS-1:0] rsp_seek_ff, rsp_seek_in;
   logic [SUM_BITS-1:0] rsp_sum_ff, rsp_sum_in;
   logic                rsp_ovf_ff, rsp_ovf_in;

   link_type            link [QUEUE_DEPTH+1];
   logic [CYL_BITS-1:0] cell_data [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] le;
   logic [CYL_BITS-1:0] req_cyl;
   logic                req_fire, full, insert, clear;
   logic [CNT_W-1:0]    split_c, split_m1, count_m1;
   logic [CYL_BITS-1:0] sel_cyl, seek_dist;
   logic [SUM_BITS:0]   sum_wide;
   logic                adv, done;

   assign req_cyl  = req_tdata[CYL_BITS-1:0];
   assign req_fire = req_tvalid && req_tready;
   assign full     = link[QUEUE_DEPTH].valid;
   assign insert   = req_fire && !full;

   assign link[0] = '{valid: 1'b0, gt: 1'b0, data: '0};

   for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      ldsk_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .clear    (clear),
         .insert   (insert),
         .cyl      (req_cyl),
         .link_in  (link[g]),
         .link_out (link[g+1])
      );
      assign cell_data[g] = link[g+1].data;
      assign le[g]        = link[g+1].valid && (link[g+1].data <= head_ff);
   end

   // sorted chain: the at-or-below-head cells form a prefix
   always_comb begin
      logic lo, hi;
      split_c = '0;
      for (int i = 0; i <= QUEUE_DEPTH; i++) begin
         lo = (i == 0) ? 1'b1 : le[(i == 0) ? 0 : i-1];
         hi = (i == QUEUE_DEPTH) ? 1'b0 : le[(i == QUEUE_DEPTH) ? 0 : i];
         if (lo && !hi) begin
            split_c = split_c | CNT_W'(i);
         end
      end
   end

   assign split_m1  = split_ff - CNT_W'(1);
   assign count_m1  = count_ff - CNT_W'(1);
   assign sel_cyl   = cell_data[ptr_ff];
   assign seek_dist = (sel_cyl >= track_ff) ? sel_cyl - track_ff : track_ff - sel_cyl;
   assign sum_wide  = {1'b0, sum_ff} + (SUM_BITS+1)'(seek_dist);
   assign adv       = !rsp_valid_ff || rsp_tready;
   assign done      = up_ff ? (CNT_W'(ptr_ff) == count_m1) && !pend_ff
                            : (ptr_ff == '0) && !pend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= HEAD_RESET;
         prev_ff <= PREV_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_HEAD_POSITION:     head_ff <= csr_wdata;
            CSR_PREVIOUS_POSITION: prev_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      drop_in      = drop_ff;
      split_in     = split_ff;
      ptr_in       = ptr_ff;
      up_in        = up_ff;
      pend_in      = pend_ff;
      track_in     = track_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_last_in  = rsp_last_ff;
      rsp_cyl_in   = rsp_cyl_ff;
      rsp_seek_in  = rsp_seek_ff;
      rsp_sum_in   = rsp_sum_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      clear        = 1'b0;
      req_tready   = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            req_tready = 1'b1;
            if (req_fire) begin
               if (full) begin
                  drop_in = 1'b1;
               end else begin
                  count_in = count_ff + CNT_W'(1);
               end
               if (req_tlast) begin
                  state_in = ST_SETUP;
               end
            end
         end
         ST_SETUP: begin
            split_in = split_c;
            track_in = head_ff;
            sum_in   = '0;
            if (head_ff >= prev_ff) begin
               if (split_c < count_ff) begin
                  ptr_in  = split_c[IDX_W-1:0];
                  up_in   = 1'b1;
                  pend_in = (split_c != '0);
               end else begin
                  ptr_in  = IDX_W'(split_c - CNT_W'(1));
                  up_in   = 1'b0;
                  pend_in = 1'b0;
               end
            end else begin
               if (split_c != '0) begin
                  ptr_in  = IDX_W'(split_c - CNT_W'(1));
                  up_in   = 1'b0;
                  pend_in = (split_c < count_ff);
               end else begin
                  ptr_in  = split_c[IDX_W-1:0];
                  up_in   = 1'b1;
                  pend_in = 1'b0;
               end
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (adv) begin
               rsp_valid_in = 1'b1;
               rsp_cyl_in   = sel_cyl;
               rsp_seek_in  = seek_dist;
               rsp_sum_in   = sum_wide[SUM_BITS] ? SUM_MAX : sum_wide[SUM_BITS-1:0];
               rsp_ovf_in   = drop_ff;
               rsp_last_in  = done;
               sum_in       = rsp_sum_in;
               track_in     = sel_cyl;
               if (done) begin
                  count_in = '0;
                  drop_in  = 1'b0;
                  clear    = 1'b1;
                  state_in = ST_LOAD;
               end else if (up_ff) begin
                  if (CNT_W'(ptr_ff) == count_m1) begin
                     ptr_in  = split_m1[IDX_W-1:0];
                     up_in   = 1'b0;
                     pend_in = 1'b0;
                  end else begin
                     ptr_in = ptr_ff + IDX_W'(1);
                  end
               end else begin
                  if (ptr_ff == '0) begin
                     ptr_in  = split_ff[IDX_W-1:0];
                     up_in   = 1'b1;
                     pend_in = 1'b0;
                  end else begin
                     ptr_in = ptr_ff - IDX_W'(1);
                  end
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      split_ff    <= split_in;
      ptr_ff      <= ptr_in;
      up_ff       <= up_in;
      pend_ff     <= pend_in;
      track_ff    <= track_in;
      sum_ff      <= sum_in;
      rsp_last_ff <= rsp_last_in;
      rsp_cyl_ff  <= rsp_cyl_in;
      rsp_seek_ff <= rsp_seek_in;
      rsp_sum_ff  <= rsp_sum_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_ovf_ff, rsp_sum_ff, rsp_seek_ff, rsp_cyl_ff});

endmodule

@@ hdl/ldsk_cell.sv @@
// ----------------------------------------------------------------------------
// ldsk_cell
// one slot of the sorted chain: emptied, or keeps its cylinder, or takes the
// neighbour's one or the new request when a smaller value is inserted
// ----------------------------------------------------------------------------
module ldsk_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      clear,
   input  logic                      insert,
   input  logic [ldsk_pkg::CYL_BITS-1:0] cyl,
   input  ldsk_pkg::link_type        link_in,
   output ldsk_pkg::link_type        link_out
);
   import ldsk_pkg::*;

   logic                valid_ff, valid_in;
   logic [CYL_BITS-1:0] data_ff, data_in;
   logic                gt;

   assign gt = !valid_ff || (data_ff > cyl);

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (clear) begin
         valid_in = 1'b0;
      end else if (insert && gt) begin
         if (link_in.gt) begin
            valid_in = link_in.valid;
            data_in  = link_in.data;
         end else begin
            valid_in = 1'b1;
            data_in  = cyl;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign link_out.valid = valid_ff;
   assign link_out.gt    = gt;
   assign link_out.data  = data_ff;

endmodule
